// ===== rtl/bcps_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary circle point search package
// Shared constants, the sine table, angle folding and the control types that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcps_pkg;

  // Image and search limits.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_RADIUS = 32;
  localparam int ANGLE_STEP = 10;

  // Derived widths.
  localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int TOTAL_W    = $clog2(MEM_DEPTH + 1);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int COORD_W    = $clog2(256 + MAX_RADIUS) + 1;
  localparam int NUM_ANGLES = (360 + ANGLE_STEP - 1) / ANGLE_STEP;
  localparam int MISS_W     = $clog2(NUM_ANGLES + 1);
  localparam int ANG_W      = 9;
  localparam int SIN_W      = 31;
  localparam int SIN_IDX_W  = 7;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_MIN_RADIUS   = 3'd2,
    CFG_MAX_RADIUS   = 3'd3,
    CFG_MISS_LIMIT   = 3'd4
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_OFF,
    ST_ADDR,
    ST_READ,
    ST_EVAL,
    ST_NEXT,
    ST_HIT,
    ST_MISS
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_px;
    logic start;
    logic calc_off;
    logic calc_addr;
    logic mem_rd;
    logic sample_next;
    logic cand_next;
    logic out_hit;
    logic out_miss;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic in_bounds;
    logic miss_over;
    logic angle_last;
    logic cand_last;
    logic out_free;
  } sts_t;

  // Folded angle: table index and sign.
  typedef struct packed {
    logic                 neg;
    logic [SIN_IDX_W-1:0] idx;
  } fold_t;

  typedef logic [SIN_W-1:0] sine_tab_t [0:90];

  // Q30 sine of each whole degree, built by a truncated Taylor series.
  function automatic sine_tab_t build_sine();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int d = 0; d <= 90; d++) begin
      x    = (longint'(d) * 64'd3373259426 + 64'd90) / 180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 342; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 420; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 506; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 600; sum = sum + longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
        sum = longint'(1) << 30;
      end
      tab[d] = sum[SIN_W-1:0];
    end
    // Exact entries.
    tab[0]  = '0;
    tab[30] = SIN_W'(32'd1 << 29);
    tab[90] = SIN_W'(32'd1 << 30);
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Folds an angle in 0..359 onto the first quadrant.
  function automatic fold_t fold_angle(input logic [ANG_W-1:0] a);
    fold_t f;
    if (a <= ANG_W'(90)) begin
      f.neg = 1'b0;
      f.idx = SIN_IDX_W'(a);
    end else if (a <= ANG_W'(180)) begin
      f.neg = 1'b0;
      f.idx = SIN_IDX_W'(ANG_W'(180) - a);
    end else if (a <= ANG_W'(270)) begin
      f.neg = 1'b1;
      f.idx = SIN_IDX_W'(a - ANG_W'(180));
    end else begin
      f.neg = 1'b1;
      f.idx = SIN_IDX_W'(ANG_W'(360) - a);
    end
    return f;
  endfunction

endpackage

// ===== rtl/bcps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Binary circle point search controller
// Sequences pixel loads, the candidate and sample loops of a search, and the
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module bcps_ctrl import bcps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic command_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (command_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_CHECK;
          end else begin
            cmd_o.load_px = 1'b1;
          end
        end
      end
      ST_START: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.empty ? ST_MISS : ST_OFF;
      end
      ST_OFF: begin
        cmd_o.calc_off = 1'b1;
        state_d        = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.calc_addr = 1'b1;
        state_d         = ST_READ;
      end
      ST_READ: begin
        if (sts_i.in_bounds) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_EVAL;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_EVAL: begin
        if (sts_i.miss_over) begin
          state_d = ST_NEXT;
        end else if (sts_i.angle_last) begin
          state_d = ST_HIT;
        end else begin
          cmd_o.sample_next = 1'b1;
          state_d           = ST_OFF;
        end
      end
      ST_NEXT: begin
        if (sts_i.cand_last) begin
          state_d = ST_MISS;
        end else begin
          cmd_o.cand_next = 1'b1;
          state_d         = ST_OFF;
        end
      end
      ST_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_hit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (sts_i.out_free) begin
          cmd_o.out_miss = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bcps_datapath.sv =====
// ----------------------------------------------------------------------------
// Binary circle point search datapath
// Configuration registers, the one-bit image memory, the loop counters, the
// offset multipliers, the bounds test and the result register.
// ----------------------------------------------------------------------------
module bcps_datapath import bcps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic [7:0] pixel_byte_i,
  input  logic [7:0] rect_left_i,
  input  logic [7:0] rect_right_i,
  input  logic [7:0] rect_top_i,
  input  logic [7:0] rect_bottom_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic       circle_found_o,
  output logic [6:0] centre_x_o,
  output logic [6:0] centre_y_o,
  output logic [5:0] circle_radius_o
);

  // Configuration registers.
  logic [7:0] width_q, height_q;
  logic [5:0] min_r_q, max_r_q, miss_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= 8'd128;
      height_q     <= 8'd128;
      min_r_q      <= 6'd4;
      max_r_q      <= 6'd16;
      miss_limit_q <= 6'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q      <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q     <= cfg_data_i;
        CFG_MIN_RADIUS:   min_r_q      <= cfg_data_i[5:0];
        CFG_MAX_RADIUS:   max_r_q      <= cfg_data_i[5:0];
        CFG_MISS_LIMIT:   miss_limit_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Effective image size and radius range.
  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;
  logic [RAD_W-1:0] eff_rmin, eff_rmax;

  always_comb begin
    if (width_q == 8'd0) begin
      eff_w = WID_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(width_q);
    end
    if (height_q == 8'd0) begin
      eff_h = HGT_W'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(height_q);
    end
    eff_rmin = (int'(min_r_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(min_r_q);
    eff_rmax = (int'(max_r_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(max_r_q);
  end

  // Load address with wrap at the active image size.
  logic [ADDR_W-1:0]  load_addr_q, load_addr_d;
  logic [ADDR_W-1:0]  wr_addr;
  logic [TOTAL_W-1:0] total;
  logic [ADDR_W:0]    wr_next;

  always_comb begin
    total   = TOTAL_W'(eff_w) * TOTAL_W'(eff_h);
    wr_addr = ({1'b0, load_addr_q} >= (ADDR_W + 1)'(total)) ? '0 : load_addr_q;
    wr_next = {1'b0, wr_addr} + 1'b1;
    load_addr_d = (wr_next >= (ADDR_W + 1)'(total)) ? '0 : wr_next[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_addr_q <= '0;
    end else if (cmd_i.load_px) begin
      load_addr_q <= load_addr_d;
    end
  end

  // Image memory: one write port for loads, one registered read port.
  logic              mem_q [0:MEM_DEPTH-1];
  logic              rd_bit_q;
  logic [X_W-1:0]    tx_q;
  logic [Y_W-1:0]    ty_q;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_addr = ADDR_W'(ty_q) * ADDR_W'(eff_w) + ADDR_W'(tx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px) begin
      mem_q[wr_addr] <= (pixel_byte_i == 8'hFF);
    end
    if (cmd_i.mem_rd) begin
      rd_bit_q <= mem_q[rd_addr];
    end
  end

  // Search bounds and loop counters.
  logic [7:0]        left_q, right_q, top_q, bottom_q;
  logic [7:0]        x_q, y_q;
  logic [RAD_W-1:0]  r_q, rmax_q;
  logic [ANG_W-1:0]  ang_q;
  logic [MISS_W-1:0] miss_q;
  logic              x_last, y_last, r_last;
  logic [MISS_W:0]   miss_sum;

  assign x_last   = ({1'b0, x_q} + 9'd1) >= {1'b0, right_q};
  assign y_last   = ({1'b0, y_q} + 9'd1) >= {1'b0, bottom_q};
  assign r_last   = (r_q == rmax_q);
  assign miss_sum = {1'b0, miss_q} + (MISS_W + 1)'(!rd_bit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      left_q   <= rect_left_i;
      right_q  <= rect_right_i;
      top_q    <= rect_top_i;
      bottom_q <= rect_bottom_i;
      x_q      <= rect_left_i;
      y_q      <= rect_top_i;
      r_q      <= eff_rmin;
      rmax_q   <= eff_rmax;
      ang_q    <= '0;
      miss_q   <= '0;
    end else if (cmd_i.sample_next) begin
      ang_q  <= ang_q + ANG_W'(ANGLE_STEP);
      miss_q <= miss_sum[MISS_W-1:0];
    end else if (cmd_i.cand_next) begin
      ang_q  <= '0;
      miss_q <= '0;
      if (y_last) begin
        y_q <= top_q;
        if (x_last) begin
          x_q <= left_q;
          r_q <= r_q + 1'b1;
        end else begin
          x_q <= x_q + 8'd1;
        end
      end else begin
        y_q <= y_q + 8'd1;
      end
    end
  end

  // Sample offsets: radius times folded sine, truncated toward zero.
  logic [ANG_W-1:0]         cos_ang;
  fold_t                    fold_c, fold_s;
  logic [RAD_W+SIN_W-1:0]   prod_c, prod_s;
  logic [RAD_W:0]           mag_c, mag_s;
  logic signed [COORD_W-1:0] off_x_q, off_y_q;

  always_comb begin
    cos_ang = (ang_q >= ANG_W'(270)) ? ang_q - ANG_W'(270) : ang_q + ANG_W'(90);
    fold_c  = fold_angle(cos_ang);
    fold_s  = fold_angle(ang_q);
    prod_c  = (RAD_W + SIN_W)'(r_q) * (RAD_W + SIN_W)'(SINE_TAB[fold_c.idx]);
    prod_s  = (RAD_W + SIN_W)'(r_q) * (RAD_W + SIN_W)'(SINE_TAB[fold_s.idx]);
    mag_c   = prod_c[RAD_W+SIN_W-1:30];
    mag_s   = prod_s[RAD_W+SIN_W-1:30];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_off) begin
      off_x_q <= fold_c.neg ? -$signed(COORD_W'(mag_c)) : $signed(COORD_W'(mag_c));
      off_y_q <= fold_s.neg ? -$signed(COORD_W'(mag_s)) : $signed(COORD_W'(mag_s));
    end
  end

  // Sample point and bounds test.
  logic signed [COORD_W-1:0] tx, ty;
  logic                      inb, inb_q;

  always_comb begin
    tx  = $signed(COORD_W'(x_q)) + off_x_q;
    ty  = $signed(COORD_W'(y_q)) + off_y_q;
    inb = (tx > 0) && (tx < $signed(COORD_W'(eff_w))) &&
          (ty > 0) && (ty < $signed(COORD_W'(eff_h)));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_addr) begin
      inb_q <= inb;
      tx_q  <= tx[X_W-1:0];
      ty_q  <= ty[Y_W-1:0];
    end
  end

  // Result register.
  logic out_valid_q;
  logic out_found_q;
  logic [6:0] out_x_q, out_y_q;
  logic [5:0] out_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_hit || cmd_i.out_miss) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_hit) begin
      out_found_q <= 1'b1;
      out_x_q     <= x_q[6:0];
      out_y_q     <= y_q[6:0];
      out_r_q     <= 6'(r_q);
    end else if (cmd_i.out_miss) begin
      out_found_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_r_q     <= '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign circle_found_o  = out_found_q;
  assign centre_x_o      = out_x_q;
  assign centre_y_o      = out_y_q;
  assign circle_radius_o = out_r_q;

  // Status to the controller.
  always_comb begin
    sts_o.empty      = (r_q > rmax_q) || (left_q >= right_q) || (top_q >= bottom_q);
    sts_o.in_bounds  = inb_q;
    sts_o.miss_over  = miss_sum > (MISS_W + 1)'(miss_limit_q);
    sts_o.angle_last = ({1'b0, ang_q} + (ANG_W + 1)'(ANGLE_STEP)) >= (ANG_W + 1)'(360);
    sts_o.cand_last  = x_last && y_last && r_last;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== rtl/binary_circle_point_search_unit.sv =====
// ----------------------------------------------------------------------------
// Binary circle point search unit
// Stores a one-bit image and searches a rectangle for the first circle whose
// sampled points are mostly set.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): command 0 loads one pixel into
//   the image in raster order; command 1 starts a search over the given
//   rectangle. Loads do not stall the input, so pixels stream in back to
//   back. A search stalls the input until it finishes. Each in-bounds
//   sample point goes through offset multiply, bounds test, memory read
//   and miss count in turn, and a rejected candidate then steps the loops.
//   Output channel (out_valid_o / out_stall_i): one transaction per search,
//   held in an output register; loads and a new search are accepted while
//   it waits, and a finished search waits for the register to drain.
//   Configuration (cfg_valid_i / cfg_ready_o) is always ready; write it only
//   while no search is running. Reset clears the load address and restores
//   the register defaults; image contents are undefined until loaded.
// ----------------------------------------------------------------------------
module binary_circle_point_search_unit import bcps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] pixel_byte_i,
  input  logic [7:0] rect_left_i,
  input  logic [7:0] rect_right_i,
  input  logic [7:0] rect_top_i,
  input  logic [7:0] rect_bottom_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       circle_found_o,
  output logic [6:0] centre_x_o,
  output logic [6:0] centre_y_o,
  output logic [5:0] circle_radius_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  bcps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Image store, counters and arithmetic.
  bcps_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_byte_i    (pixel_byte_i),
    .rect_left_i     (rect_left_i),
    .rect_right_i    (rect_right_i),
    .rect_top_i      (rect_top_i),
    .rect_bottom_i   (rect_bottom_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .circle_found_o  (circle_found_o),
    .centre_x_o      (centre_x_o),
    .centre_y_o      (centre_y_o),
    .circle_radius_o (circle_radius_o)
  );

endmodule
